// File: design/phb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase-space histogram binner package
// Shared widths, register indexes and the lane/merge result types.
// ----------------------------------------------------------------------------
package phb_pkg;

    localparam int POSITION_DIMS = 2;
    localparam int VELOCITY_DIMS = 2;
    localparam int TOTAL_DIMS    = POSITION_DIMS + VELOCITY_DIMS;
    localparam int DIM_IDX_W     = $clog2(TOTAL_DIMS);

    localparam int COORD_W  = 16;
    localparam int FIELD_W  = 16;
    localparam int BINS_W   = 8;
    localparam int TIME_W   = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam int HIST_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int COUNT_W    = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // time (unsigned) times speed (signed Q8.8), then floor divide by 256
    localparam int WPROD_W = TIME_W + 1 + FIELD_W;
    localparam int FRAC_W  = 8;
    localparam int OFF_W   = WPROD_W - FRAC_W;
    localparam int BOUND_W = OFF_W + 1;
    localparam int DIFF_W  = BOUND_W + 1;
    localparam int MAG_W   = BOUND_W;
    localparam int PROD_W  = MAG_W + FIELD_W;
    localparam int QUOT_W  = PROD_W - FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_START  = 3'd0,
        CFG_WIN_END    = 3'd1,
        CFG_INV_STRIDE = 3'd2,
        CFG_BINS       = 3'd3,
        CFG_INTEGRATE  = 3'd4,
        CFG_SPEED      = 3'd5,
        CFG_TIME       = 3'd6
    } t_cfg_idx;

    localparam logic [31:0] BINS_RESET = 32'h0101_0101;

    typedef struct packed {
        logic              valid;
        logic              in_win;
        logic [BINS_W-1:0] bin;
        logic [BINS_W-1:0] size;
    } t_lane_res;

    typedef struct packed {
        logic              done;
        logic              in_space;
        logic [ADDR_W-1:0] addr;
    } t_merge_res;

endpackage

// File: design/phb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module phb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/phb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dimension lane
// Window test and bin number for one coordinate, four register stages.
// ----------------------------------------------------------------------------
module phb_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [phb_pkg::COORD_W-1:0]   i_coord,
    input  logic signed [phb_pkg::FIELD_W-1:0]   i_win_start,
    input  logic signed [phb_pkg::FIELD_W-1:0]   i_win_end,
    input  logic signed [phb_pkg::OFF_W-1:0]     i_offset,
    input  logic        [phb_pkg::FIELD_W-1:0]   i_inv_stride,
    input  logic        [phb_pkg::BINS_W-1:0]    i_bins,
    input  logic                                 i_integ,
    output phb_pkg::t_lane_res                   o_res
);
    import phb_pkg::*;

    // stage 1: moved bounds
    logic                      r1_valid;
    logic signed [BOUND_W-1:0] r1_lo;
    logic signed [BOUND_W-1:0] r1_hi;
    logic signed [BOUND_W-1:0] r1_x;
    // stage 2: window test and distance from the lower bound
    logic                      r2_valid;
    logic                      r2_in;
    logic                      r2_pos;
    logic [MAG_W-1:0]          r2_diff;
    // stage 3: scaled distance
    logic                      r3_valid;
    logic                      r3_in;
    logic                      r3_pos;
    logic [PROD_W-1:0]         r3_prod;
    // stage 4: result
    t_lane_res                 r4_res;

    logic signed [DIFF_W-1:0]  n_diff;
    logic [QUOT_W-1:0]         w_quot;
    logic [BINS_W-1:0]         w_nb;
    logic [BINS_W-1:0]         w_top;
    t_lane_res                 n_res;

    assign n_diff = DIFF_W'(r1_x) - DIFF_W'(r1_lo);
    assign w_quot = r3_prod[PROD_W-1:FRAC_W];
    assign w_nb   = (i_bins == '0) ? BINS_W'(1) : i_bins;
    assign w_top  = w_nb - BINS_W'(1);

    always_comb begin
        n_res.valid  = r3_valid;
        n_res.in_win = r3_in;
        if (i_integ) begin
            n_res.size = BINS_W'(1);
            n_res.bin  = '0;
        end else begin
            n_res.size = w_nb;
            if (!r3_pos) begin
                n_res.bin = '0;
            end else if (w_quot > QUOT_W'(w_top)) begin
                n_res.bin = w_top;
            end else begin
                n_res.bin = w_quot[BINS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_res   <= '0;
        end else begin
            r1_valid     <= i_start;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            if (r3_valid) begin
                r4_res <= n_res;
            end else begin
                r4_res.valid <= 1'b0;
            end
        end
        if (i_start) begin
            r1_lo <= BOUND_W'(i_win_start) + BOUND_W'(i_offset);
            r1_hi <= BOUND_W'(i_win_end) + BOUND_W'(i_offset);
            r1_x  <= BOUND_W'(i_coord);
        end
        if (r1_valid) begin
            // an empty-width window lets everything through
            r2_in   <= (r1_x >= r1_lo && r1_x < r1_hi) || (r1_lo == r1_hi);
            r2_pos  <= !n_diff[DIFF_W-1] && (n_diff != '0);
            r2_diff <= n_diff[MAG_W-1:0];
        end
        if (r2_valid) begin
            r3_in   <= r2_in;
            r3_pos  <= r2_pos;
            r3_prod <= PROD_W'(r2_diff) * PROD_W'(i_inv_stride);
        end
    end

    assign o_res = r4_res;

endmodule

// File: design/phb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane merge
// Folds the lane bins into a row-major address, one dimension per cycle.
// ----------------------------------------------------------------------------
module phb_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  phb_pkg::t_lane_res  i_res [phb_pkg::TOTAL_DIMS],
    output phb_pkg::t_merge_res o_res
);
    import phb_pkg::*;

    localparam logic [DIM_IDX_W-1:0] LAST_DIM = DIM_IDX_W'(TOTAL_DIMS - 1);
    localparam int MAC_W = ADDR_W + BINS_W + 1;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_in;
    logic [DIM_IDX_W-1:0] r_idx;
    logic [ADDR_W-1:0]    r_addr;

    logic                 w_all_in;
    t_lane_res            w_cur;
    logic [MAC_W-1:0]     n_mac;

    always_comb begin
        w_all_in = 1'b1;
        for (int d = 0; d < TOTAL_DIMS; d++) begin
            w_all_in = w_all_in & i_res[d].in_win;
        end
    end

    assign w_cur = i_res[r_idx];
    assign n_mac = MAC_W'(r_addr) * MAC_W'(w_cur.size) + MAC_W'(w_cur.bin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_res[0].valid && r_busy && (r_idx == LAST_DIM);
            if (i_res[0].valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_addr <= '0;
                r_in   <= w_all_in;
            end else if (r_busy) begin
                // reduce modulo the histogram depth as each dimension folds in
                r_addr <= n_mac[ADDR_W-1:0];
                r_idx  <= r_idx + DIM_IDX_W'(1);
                if (r_idx == LAST_DIM) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.in_space = r_in;
    assign o_res.addr     = r_addr;

endmodule

// File: design/phase_space_histogram_binner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase-space histogram binner
// Bins particles into a saturating counter histogram; reads and clears counters.
// ----------------------------------------------------------------------------
// Input channel i_valid / o_stall carries one word: i_cmd selects binning of
// the particle coordinates (0) or read-and-clear of i_read_address (1).
// Output channel o_valid / i_stall returns one word per input word: in-space
// flag, histogram address and counter value.
// One word is in flight at a time. A binning word runs four dimension lanes
// in parallel (four stages), then the merge folds one dimension per cycle,
// then a read-modify-write of the counter RAM; the RAM fetch is skipped when
// the particle falls outside a window. A read word fetches the counter,
// returns it and clears the entry.
// The result sits in an output register, so the next word is taken while it
// waits; a new result is held back until the receiver takes the previous one.
// After reset the counter RAM is swept to zero, one entry a cycle, through all
// 4096 entries with o_stall high; configuration writes are taken throughout.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
module phase_space_histogram_binner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [phb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [phb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_cmd,
    input  logic signed [phb_pkg::COORD_W-1:0]   i_position_0,
    input  logic signed [phb_pkg::COORD_W-1:0]   i_position_1,
    input  logic signed [phb_pkg::COORD_W-1:0]   i_velocity_0,
    input  logic signed [phb_pkg::COORD_W-1:0]   i_velocity_1,
    input  logic        [phb_pkg::ADDR_W-1:0]    i_read_address,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_in_space,
    output logic        [phb_pkg::ADDR_W-1:0]    o_bin_address,
    output logic        [phb_pkg::COUNT_W-1:0]   o_count
);
    import phb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN,
        S_WAIT,
        S_FETCH,
        S_UPDATE
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HIST_DEPTH - 1);

    // configuration
    logic [CFG_W-1:0]         r_win_start;
    logic [CFG_W-1:0]         r_win_end;
    logic [CFG_W-1:0]         r_inv_stride;
    logic [TOTAL_DIMS*BINS_W-1:0] r_bins;
    logic [TOTAL_DIMS-1:0]    r_integ;
    logic [POSITION_DIMS*FIELD_W-1:0] r_speed;
    logic [TIME_W-1:0]        r_time;
    logic signed [WPROD_W-1:0] r_wprod [POSITION_DIMS];

    // control and word state
    t_state                   r_state;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     r_is_read;
    logic                     r_in_space;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [COORD_W-1:0] r_coord [TOTAL_DIMS];
    logic                     r_out_valid;
    logic                     r_out_in_space;
    logic [ADDR_W-1:0]        r_out_addr;
    logic [COUNT_W-1:0]       r_out_count;

    logic signed [OFF_W-1:0]  w_off [TOTAL_DIMS];
    t_lane_res                w_lane [TOTAL_DIMS];
    t_merge_res               w_merge;
    logic                     w_out_free;
    logic                     w_write;
    logic [COUNT_W-1:0]       w_rdata;
    logic [COUNT_W-1:0]       w_inc;
    logic [COUNT_W-1:0]       w_count;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [COUNT_W-1:0]       w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start  <= '0;
            r_win_end    <= '0;
            r_inv_stride <= '0;
            r_bins       <= BINS_RESET;
            r_integ      <= '0;
            r_speed      <= '0;
            r_time       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_START:  r_win_start  <= i_cfg_data;
                CFG_WIN_END:    r_win_end    <= i_cfg_data;
                CFG_INV_STRIDE: r_inv_stride <= i_cfg_data;
                CFG_BINS:       r_bins       <= i_cfg_data[TOTAL_DIMS*BINS_W-1:0];
                CFG_INTEGRATE:  r_integ      <= i_cfg_data[TOTAL_DIMS-1:0];
                CFG_SPEED:      r_speed      <= i_cfg_data[POSITION_DIMS*FIELD_W-1:0];
                CFG_TIME:       r_time       <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // window offset per position dimension; the low byte drop is a floor divide
    for (genvar p = 0; p < POSITION_DIMS; p++) begin : g_offset
        always_ff @(posedge i_clk) begin
            r_wprod[p] <= $signed({1'b0, r_time}) * $signed(r_speed[p*FIELD_W +: FIELD_W]);
        end
    end

    for (genvar g = 0; g < TOTAL_DIMS; g++) begin : g_lane
        if (g < POSITION_DIMS) begin : g_pos
            assign w_off[g] = r_wprod[g][WPROD_W-1:FRAC_W];
        end else begin : g_vel
            assign w_off[g] = '0;
        end

        phb_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_start      (r_state == S_BIN),
            .i_coord      (r_coord[g]),
            .i_win_start  (r_win_start[g*FIELD_W +: FIELD_W]),
            .i_win_end    (r_win_end[g*FIELD_W +: FIELD_W]),
            .i_offset     (w_off[g]),
            .i_inv_stride (r_inv_stride[g*FIELD_W +: FIELD_W]),
            .i_bins       (r_bins[g*BINS_W +: BINS_W]),
            .i_integ      (r_integ[g]),
            .o_res        (w_lane[g])
        );
    end

    phb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_lane),
        .o_res   (w_merge)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_write    = (r_state == S_UPDATE) && w_out_free;
    assign w_inc      = (w_rdata == COUNT_MAX) ? w_rdata : w_rdata + COUNT_W'(1);

    always_comb begin
        if (r_is_read) begin
            w_count = w_rdata;
        end else if (r_in_space) begin
            w_count = w_inc;
        end else begin
            w_count = '0;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_write && (r_is_read || r_in_space);
            w_waddr = r_addr;
            w_wdata = r_is_read ? '0 : w_inc;
        end
    end

    phb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == S_FETCH),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !w_write) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_coord[0] <= i_position_0;
                        r_coord[1] <= i_position_1;
                        r_coord[2] <= i_velocity_0;
                        r_coord[3] <= i_velocity_1;
                        r_is_read  <= i_cmd;
                        r_in_space <= 1'b0;
                        r_addr     <= i_read_address;
                        r_state    <= i_cmd ? S_FETCH : S_BIN;
                    end
                end
                S_BIN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_merge.done) begin
                        r_in_space <= w_merge.in_space;
                        r_addr     <= w_merge.in_space ? w_merge.addr : '0;
                        // out of space: skip the fetch, nothing to count
                        r_state    <= w_merge.in_space ? S_FETCH : S_UPDATE;
                    end
                end
                S_FETCH: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_in_space <= r_in_space;
                        r_out_addr     <= r_addr;
                        r_out_count    <= w_count;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_in_space    = r_out_in_space;
    assign o_bin_address = r_out_addr;
    assign o_count       = r_out_count;

endmodule
